// File: hdl/astm_pkg.sv
package astm_pkg;

   localparam int ROW_W      = 10;
   localparam int COL_W      = 10;
   localparam int SIZE_W     = 11;
   localparam int STEP_W     = 32;
   localparam int KSQ_W      = 62;
   localparam int DIST_W     = 48;
   localparam int SPEC_W     = 32;
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 64;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 62;

   localparam int DEF_MAX_ROWS        = 1024;
   localparam int DEF_MAX_COLS        = 1024;
   localparam int DEF_PHASE_FRAC_BITS = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ROWS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COLS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KX_STEP   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KY_STEP   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WAVENUM   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DIST_TURN = 3'd5;

   localparam int SQRT_STEPS   = 45;
   localparam int CORDIC_STEPS = 24;
   localparam int CORDIC_W     = 34;
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

   localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   // stage numbers of the pipeline
   localparam int ST_CMP = 5;
   localparam int ST_SQ0 = 6;
   localparam int ST_MUL = ST_SQ0 + SQRT_STEPS + 3 + CORDIC_STEPS;
   localparam int LAT    = ST_MUL + 1;

   typedef struct packed {
      logic signed [SPEC_W-1:0] re;
      logic signed [SPEC_W-1:0] im;
      logic                     evan;
   } side_type;

endpackage

// File: hdl/angular_spectrum_transfer_multiply.sv
// Angular-spectrum transfer multiply. The rate is one spectrum word per cycle, set
// by a single pipeline that advances as a whole whenever the output register is
// empty or being taken. Stages: centre offset, kx/ky, split squares, sum, compare
// with k^2, 45 one-bit square-root stages, phase product in two stages, CORDIC
// set-up and 24 CORDIC stages, complex multiply, then round and saturate. The user
// must write registers only while no word is in flight; the block itself does not
// enforce this.
module angular_spectrum_transfer_multiply import astm_pkg::*; #(
   parameter int MAX_ROWS        = DEF_MAX_ROWS,
   parameter int MAX_COLS        = DEF_MAX_COLS,
   parameter int PHASE_FRAC_BITS = DEF_PHASE_FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // row_index, col_index, spec_re, spec_im
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // prop_re, prop_im
   output logic                  rsp_tuser,  // evanescent
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [SIZE_W-1:0] num_rows_ff, num_cols_ff;
   logic [STEP_W-1:0] kx_step_ff, ky_step_ff;
   logic [KSQ_W-1:0]  wavenum_ff;
   logic [DIST_W-1:0] dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff <= SIZE_W'(1024);
         num_cols_ff <= SIZE_W'(1024);
         kx_step_ff  <= '0;
         ky_step_ff  <= '0;
         wavenum_ff  <= '0;
         dist_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NUM_ROWS:  num_rows_ff <= csr_wdata[SIZE_W-1:0];
            CSR_NUM_COLS:  num_cols_ff <= csr_wdata[SIZE_W-1:0];
            CSR_KX_STEP:   kx_step_ff  <= csr_wdata[STEP_W-1:0];
            CSR_KY_STEP:   ky_step_ff  <= csr_wdata[STEP_W-1:0];
            CSR_WAVENUM:   wavenum_ff  <= csr_wdata[KSQ_W-1:0];
            CSR_DIST_TURN: dist_ff     <= csr_wdata[DIST_W-1:0];
            default: ;
         endcase
      end
   end

   logic adv;
   logic [LAT:1] valid_ff;
   side_type side_ff [1:LAT-1];

   assign adv        = !valid_ff[LAT] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = valid_ff[LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[LAT-1:1], req_tvalid};
      end
   end

   // stage 1: offsets from the centre
   logic [SIZE_W-1:0] n_rows, n_cols, c_row, c_col, idx_r, idx_c, off_r, off_c;
   logic [ROW_W-1:0]  off_x_ff;
   logic [COL_W-1:0]  off_y_ff;

   always_comb begin
      n_rows = (13'(num_rows_ff) > 13'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : num_rows_ff;
      n_cols = (13'(num_cols_ff) > 13'(MAX_COLS)) ? SIZE_W'(MAX_COLS) : num_cols_ff;
      c_row  = n_rows >> 1;
      c_col  = n_cols >> 1;
      idx_r  = SIZE_W'(req_tdata[ROW_W-1:0]);
      idx_c  = SIZE_W'(req_tdata[ROW_W+COL_W-1:ROW_W]);
      off_r  = (idx_r >= c_row) ? idx_r - c_row : c_row - idx_r;
      off_c  = (idx_c >= c_col) ? idx_c - c_col : c_col - idx_c;
   end

   // stages 2..5: kx, ky, split squares, sum, compare
   logic [41:0] kx_ff, ky_ff;
   logic [41:0] xhh_ff, xhl_ff, xll_ff, yhh_ff, yhl_ff, yll_ff;
   logic [85:0] tsq_ff, diff_ff, k2;

   assign k2 = {wavenum_ff, 24'b0};

   always_ff @(posedge clock) begin
      if (adv) begin
         off_x_ff <= ROW_W'(off_r);
         off_y_ff <= COL_W'(off_c);
         kx_ff    <= 42'(kx_step_ff) * 42'(off_x_ff);
         ky_ff    <= 42'(ky_step_ff) * 42'(off_y_ff);
         xhh_ff   <= 42'(kx_ff[41:21]) * 42'(kx_ff[41:21]);
         xhl_ff   <= 42'(kx_ff[41:21]) * 42'(kx_ff[20:0]);
         xll_ff   <= 42'(kx_ff[20:0]) * 42'(kx_ff[20:0]);
         yhh_ff   <= 42'(ky_ff[41:21]) * 42'(ky_ff[41:21]);
         yhl_ff   <= 42'(ky_ff[41:21]) * 42'(ky_ff[20:0]);
         yll_ff   <= 42'(ky_ff[20:0]) * 42'(ky_ff[20:0]);
         tsq_ff   <= (86'(xhh_ff) << 42) + (86'(xhl_ff) << 22) + 86'(xll_ff)
                   + (86'(yhh_ff) << 42) + (86'(yhl_ff) << 22) + 86'(yll_ff);
         diff_ff  <= k2 - tsq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[1] <= {req_tdata[ROW_W+COL_W+SPEC_W-1:ROW_W+COL_W],
                        req_tdata[ROW_W+COL_W+2*SPEC_W-1:ROW_W+COL_W+SPEC_W], 1'b0};
         for (int k = 2; k < LAT; k++) begin
            if (k == ST_CMP)
               side_ff[k] <= {side_ff[k-1].re, side_ff[k-1].im, (k2 <= tsq_ff)};
            else
               side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // square root, one result bit per stage
   logic [47:0] sq_rem_ff  [SQRT_STEPS];
   logic [44:0] sq_root_ff [SQRT_STEPS];
   logic [89:0] sq_v_ff    [SQRT_STEPS];

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      logic [47:0] src_rem, rem_sh, trial;
      logic [44:0] src_root;
      logic [89:0] src_v;
      logic        ge;
      if (j == 0) begin : g_first
         assign src_rem  = '0;
         assign src_root = '0;
         assign src_v    = {4'b0, diff_ff};
      end else begin : g_next
         assign src_rem  = sq_rem_ff[j-1];
         assign src_root = sq_root_ff[j-1];
         assign src_v    = sq_v_ff[j-1];
      end
      assign rem_sh = {src_rem[45:0], src_v[89:88]};
      assign trial  = {1'b0, src_root, 2'b01};
      assign ge     = rem_sh >= trial;
      always_ff @(posedge clock) begin
         if (adv) begin
            sq_rem_ff[j]  <= ge ? rem_sh - trial : rem_sh;
            sq_root_ff[j] <= {src_root[43:0], ge};
            sq_v_ff[j]    <= {src_v[87:0], 2'b0};
         end
      end
   end

   // phase in turns, low 52 bits of kz * distance_per_turn
   logic [44:0] kz;
   logic [51:0] pll_ff, p52;
   logic [25:0] plh_ff, phl_ff;
   logic [31:0] ang_ff, q_sum, z_raw;

   assign kz    = sq_root_ff[SQRT_STEPS-1];
   assign p52   = pll_ff + {26'(plh_ff + phl_ff), 26'b0};
   assign q_sum = ang_ff + 32'h2000_0000;
   assign z_raw = ang_ff - {q_sum[31:30], 30'b0};

   always_ff @(posedge clock) begin
      if (adv) begin
         pll_ff <= 52'(kz[25:0]) * 52'(dist_ff[25:0]);
         plh_ff <= 26'(kz[25:0]) * 26'(dist_ff[47:26]);
         phl_ff <= 26'(kz[44:26]) * 26'(dist_ff[25:0]);
         ang_ff <= 32'(p52[51 -: PHASE_FRAC_BITS]) << (32 - PHASE_FRAC_BITS);
      end
   end

   // CORDIC, one rotation per stage
   logic signed [CORDIC_W-1:0] cx_ff [CORDIC_STEPS+1];
   logic signed [CORDIC_W-1:0] cy_ff [CORDIC_STEPS+1];
   logic signed [CORDIC_W-1:0] cz_ff [CORDIC_STEPS+1];
   logic [1:0]                 cq_ff [CORDIC_STEPS+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         cx_ff[0] <= CORDIC_GAIN;
         cy_ff[0] <= '0;
         cz_ff[0] <= {{(CORDIC_W-32){z_raw[31]}}, z_raw};
         cq_ff[0] <= q_sum[31:30];
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      logic signed [CORDIC_W-1:0] dx, dy, at;
      assign dx = cy_ff[i] >>> i;
      assign dy = cx_ff[i] >>> i;
      assign at = CORDIC_W'(ATAN_TURNS[i]);
      always_ff @(posedge clock) begin
         if (adv) begin
            cq_ff[i+1] <= cq_ff[i];
            if (!cz_ff[i][CORDIC_W-1]) begin
               cx_ff[i+1] <= cx_ff[i] - dx;
               cy_ff[i+1] <= cy_ff[i] + dy;
               cz_ff[i+1] <= cz_ff[i] - at;
            end else begin
               cx_ff[i+1] <= cx_ff[i] + dx;
               cy_ff[i+1] <= cy_ff[i] - dy;
               cz_ff[i+1] <= cz_ff[i] + at;
            end
         end
      end
   end

   // quadrant and complex multiply
   logic signed [CORDIC_W-1:0] cos_v, sin_v, fx, fy;
   logic signed [65:0] prc_ff, pis_ff, pic_ff, prs_ff;

   assign fx = cx_ff[CORDIC_STEPS];
   assign fy = cy_ff[CORDIC_STEPS];

   always_comb begin
      case (cq_ff[CORDIC_STEPS])
         2'd1:    begin cos_v = -fy; sin_v = fx;  end
         2'd2:    begin cos_v = -fx; sin_v = -fy; end
         2'd3:    begin cos_v = fy;  sin_v = -fx; end
         default: begin cos_v = fx;  sin_v = fy;  end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prc_ff <= 66'(side_ff[ST_MUL-1].re) * 66'(cos_v);
         pis_ff <= 66'(side_ff[ST_MUL-1].im) * 66'(sin_v);
         pic_ff <= 66'(side_ff[ST_MUL-1].im) * 66'(cos_v);
         prs_ff <= 66'(side_ff[ST_MUL-1].re) * 66'(sin_v);
      end
   end

   // round half up, saturate, bypass evanescent words
   logic signed [67:0] sum_r, sum_i, sh_r, sh_i;
   logic signed [SPEC_W-1:0] sat_r, sat_i, out_re_ff, out_im_ff;
   logic out_evan_ff;

   function automatic logic signed [SPEC_W-1:0] sat32(input logic signed [67:0] v);
      logic signed [SPEC_W-1:0] r;
      if (v > 68'sh0_0000_0000_7FFF_FFFF)
         r = 32'sh7FFF_FFFF;
      else if (v < -68'sh0_0000_0000_8000_0000)
         r = 32'sh8000_0000;
      else
         r = v[SPEC_W-1:0];
      return r;
   endfunction

   always_comb begin
      sum_r = 68'(prc_ff) - 68'(pis_ff) + 68'sd536870912;
      sum_i = 68'(pic_ff) + 68'(prs_ff) + 68'sd536870912;
      sh_r  = sum_r >>> 30;
      sh_i  = sum_i >>> 30;
      sat_r = sat32(sh_r);
      sat_i = sat32(sh_i);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_evan_ff <= side_ff[LAT-1].evan;
         out_re_ff   <= side_ff[LAT-1].evan ? side_ff[LAT-1].re : sat_r;
         out_im_ff   <= side_ff[LAT-1].evan ? side_ff[LAT-1].im : sat_i;
      end
   end

   assign rsp_tdata = {out_im_ff, out_re_ff};
   assign rsp_tuser = out_evan_ff;

endmodule

// File: hdl/astm_checker.sv
module astm_checker import astm_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("input held off while output is free");

   a_stall_only_on_output: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input held off without an output stall");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word present after reset");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> ($stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result word changed");

endmodule

bind angular_spectrum_transfer_multiply astm_checker u_astm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import astm_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd6;
   localparam int DRAIN_LIMIT = 20000;

   typedef struct {
      logic [ROW_W-1:0]         row;
      logic [COL_W-1:0]         col;
      logic signed [SPEC_W-1:0] re;
      logic signed [SPEC_W-1:0] im;
   } bin_type;

   typedef struct {
      logic signed [SPEC_W-1:0] re;
      logic signed [SPEC_W-1:0] im;
      logic                     evan;
   } prop_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic [SIZE_W-1:0] rows_r, cols_r;
   logic [STEP_W-1:0] kx_step_r, ky_step_r;
   logic [KSQ_W-1:0]  ksq_r;
   logic [DIST_W-1:0] dist_r;

   prop_type pending_props[$];
   int    mismatches = 0;
   int    idle_pct = 0;
   int    stall_pct = 0;

   angular_spectrum_transfer_multiply dut (.*);

   always #2 clock = ~clock;

   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= stall_pct);

   function automatic logic [63:0] centre_offset(logic [ROW_W-1:0] idx, logic [SIZE_W-1:0] cnt,
                                                 int maxc);
      logic [63:0] n, c;
      n = (cnt > maxc) ? 64'(maxc) : 64'(cnt);
      c = n >> 1;
      return (idx >= c) ? 64'(idx) - c : c - 64'(idx);
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic prop_type propagate_bin(bin_type b);
      logic [63:0]  kx, ky, kz, cand;
      logic [127:0] tsq, k2, rem, ph;
      logic [31:0]  ang;
      logic [1:0]   q;
      longint       x, y, z, dx, dy, t, re, im, r, i2;
      prop_type     p;
      kx = kx_step_r * centre_offset(b.row, rows_r, DEF_MAX_ROWS);
      ky = ky_step_r * centre_offset(b.col, cols_r, DEF_MAX_COLS);
      tsq = 128'(kx) * 128'(kx) + 128'(ky) * 128'(ky);
      k2 = 128'(ksq_r) << 24;
      if (k2 <= tsq) begin
         p.re = b.re;
         p.im = b.im;
         p.evan = 1'b1;
         return p;
      end
      rem = k2 - tsq;
      kz = '0;
      for (int i = SQRT_STEPS - 1; i >= 0; i--) begin
         cand = kz | (64'd1 << i);
         if (128'(cand) * 128'(cand) <= rem) kz = cand;
      end
      ph = 128'(kz) * 128'(dist_r);
      ang = 32'(((ph >> (52 - DEF_PHASE_FRAC_BITS)) & ((128'd1 << DEF_PHASE_FRAC_BITS) - 1))
                << (32 - DEF_PHASE_FRAC_BITS));
      q = 2'((ang + 32'h2000_0000) >> 30);
      z = longint'(signed'(32'(ang - {q, 30'd0})));
      x = longint'(CORDIC_GAIN);
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(ATAN_TURNS[i]);
         end else begin
            x += dx; y -= dy; z += longint'(ATAN_TURNS[i]);
         end
      end
      case (q)
         2'd1: begin t = x; x = -y; y = t; end
         2'd2: begin x = -x; y = -y; end
         2'd3: begin t = x; x = y; y = -t; end
         default: ;
      endcase
      re = longint'(b.re);
      im = longint'(b.im);
      r = (re * x - im * y + (64'sd1 <<< 29)) >>> 30;
      i2 = (im * x + re * y + (64'sd1 <<< 29)) >>> 30;
      p.re = 32'(clamp32(r));
      p.im = 32'(clamp32(i2));
      p.evan = 1'b0;
      return p;
   endfunction

   always @(posedge clock) begin
      prop_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_props.size() == 0) begin
            $error("unexpected result word re=%0d im=%0d", $signed(rsp_tdata[31:0]),
                   $signed(rsp_tdata[63:32]));
            mismatches++;
         end else begin
            e = pending_props.pop_front();
            if (rsp_tdata[31:0] !== e.re) begin
               $error("prop_re expected %0d actual %0d", e.re, $signed(rsp_tdata[31:0]));
               mismatches++;
            end
            if (rsp_tdata[63:32] !== e.im) begin
               $error("prop_im expected %0d actual %0d", e.im, $signed(rsp_tdata[63:32]));
               mismatches++;
            end
            if (rsp_tuser !== e.evan) begin
               $error("evanescent expected %0b actual %0b", e.evan, rsp_tuser);
               mismatches++;
            end
         end
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [63:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_NUM_ROWS:  rows_r = val[SIZE_W-1:0];
         CSR_NUM_COLS:  cols_r = val[SIZE_W-1:0];
         CSR_KX_STEP:   kx_step_r = val[STEP_W-1:0];
         CSR_KY_STEP:   ky_step_r = val[STEP_W-1:0];
         CSR_WAVENUM:   ksq_r = val[KSQ_W-1:0];
         CSR_DIST_TURN: dist_r = val[DIST_W-1:0];
         default: ;
      endcase
   endtask

   task automatic send_bin(bin_type b);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'd0, b.im, b.re, b.col, b.row};
      do @(posedge clock); while (!req_tready);
      pending_props.push_back(propagate_bin(b));
   endtask

   task automatic send(int row, int col, longint re, longint im);
      bin_type b;
      b.row = ROW_W'(row); b.col = COL_W'(col); b.re = SPEC_W'(re); b.im = SPEC_W'(im);
      send_bin(b);
   endtask

   task automatic drain();
      int waited = 0;
      req_tvalid <= 1'b0;
      while (pending_props.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (LAT + 10) @(posedge clock);
   endtask

   task automatic random_config();
      logic [63:0] stp, lim;
      write_reg(CSR_NUM_ROWS, 64'($urandom_range(2, 1024)));
      write_reg(CSR_NUM_COLS, 64'($urandom_range(2, 1024)));
      write_reg(CSR_KX_STEP, 64'($urandom_range(1, 1 << 20)));
      write_reg(CSR_KY_STEP, 64'($urandom_range(1, 1 << 20)));
      stp = (kx_step_r > ky_step_r) ? 64'(kx_step_r) : 64'(ky_step_r);
      lim = ((stp * 512) * (stp * 512)) >> 24;
      write_reg(CSR_WAVENUM, {$urandom, $urandom} % (2 * lim + 1));
      write_reg(CSR_DIST_TURN, {$urandom, $urandom});
   endtask

   task automatic test_reset_defaults();
      send(0, 0, 123, -456);
      send(512, 512, 32'h7FFF_FFFF, 32'h8000_0000);
      send(1023, 1023, -1, 1);
      drain();
   endtask

   task automatic test_directed_bins();
      write_reg(CSR_NUM_ROWS, 1024);
      write_reg(CSR_NUM_COLS, 1024);
      write_reg(CSR_KX_STEP, 4096 * 200);
      write_reg(CSR_KY_STEP, 4096 * 200);
      write_reg(CSR_WAVENUM, 64'd10_000_000_000);
      write_reg(CSR_DIST_TURN, 48'h0123_4567_89AB);
      write_reg(CSR_UNUSED, 64'h3FFF_FFFF_FFFF_FFFF);
      send(512, 512, 32'h7FFF_FFFF, 32'h8000_0000);
      send(512, 512, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send(512, 512, 32'h8000_0000, 32'h8000_0000);
      send(0, 0, 1000, -1000);
      send(1023, 1023, 0, 0);
      send(0, 1023, -1, -1);
      send(512, 0, 77777, 88888);
      send(300, 700, 32'h8000_0000, 32'h7FFF_FFFF);
      drain();
      write_reg(CSR_NUM_ROWS, 0);
      write_reg(CSR_NUM_COLS, 1);
      send(0, 0, 5, 6);
      send(1023, 1, 32'h7FFF_FFFF, -7);
      drain();
      write_reg(CSR_NUM_ROWS, 2047);
      write_reg(CSR_NUM_COLS, 2);
      send(512, 1, -9, 32'h8000_0000);
      send(1023, 0, 11, 12);
      drain();
      write_reg(CSR_KX_STEP, 32'hFFFF_FFFF);
      write_reg(CSR_KY_STEP, 32'hFFFF_FFFF);
      write_reg(CSR_WAVENUM, 64'h3FFF_FFFF_FFFF_FFFF);
      write_reg(CSR_DIST_TURN, 48'hFFFF_FFFF_FFFF);
      write_reg(CSR_NUM_ROWS, 1024);
      write_reg(CSR_NUM_COLS, 1024);
      send(512, 512, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send(513, 512, 32'h8000_0000, 32'h7FFF_FFFF);
      send(0, 0, 1, 1);
      send(1023, 1023, -1, 32'h7FFF_FFFF);
      drain();
      write_reg(CSR_KX_STEP, 0);
      write_reg(CSR_KY_STEP, 0);
      write_reg(CSR_WAVENUM, 0);
      write_reg(CSR_DIST_TURN, 0);
      send(700, 200, 32'h7FFF_FFFF, 32'h8000_0000);
      drain();
   endtask

   task automatic test_random_bins(int idle, int stall, int count, bit pause_midway);
      bin_type b;
      idle_pct = idle;
      stall_pct = stall;
      random_config();
      for (int n = 0; n < count; n++) begin
         b.row = ROW_W'($urandom);
         b.col = COL_W'($urandom);
         b.re = $urandom;
         b.im = $urandom;
         if ($urandom_range(9) == 0) b.re = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         send_bin(b);
         if (pause_midway && n == count / 2) drain();
      end
      drain();
   endtask

   initial begin
      rows_r = 1024; cols_r = 1024;
      kx_step_r = 0; ky_step_r = 0; ksq_r = 0; dist_r = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_directed_bins();
      test_random_bins(0, 0, 240, 1'b1);
      test_random_bins(78, 0, 230, 1'b0);
      test_random_bins(0, 78, 230, 1'b0);
      test_random_bins(31, 31, 230, 1'b0);
      if (pending_props.size() != 0) begin
         $error("%0d expected results never arrived", pending_props.size());
         mismatches++;
      end
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// File: angular_spectrum_transfer_multiply.f
hdl/astm_pkg.sv
hdl/angular_spectrum_transfer_multiply.sv
hdl/astm_checker.sv
tb/testbench.sv
